/* rtl/core/msd_pkg.sv */
// Shared types, constants and the segment lookup for the multiplexed
// seven-segment driver. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

   // Field widths
   localparam int VALUE_W = 14;
   localparam int DWELL_W = 8;
   localparam int POS_W   = 2;
   localparam int DIGITS  = 4;
   localparam int SEG_W   = 8;
   localparam int BIT_W   = 3;
   localparam int CODE_W  = 4;
   localparam int QUOT_W  = 14;
   localparam int QDIV_W  = 11;

   // Reset value of the dwell register
   localparam logic [DWELL_W-1:0] DWELL_RESET = 8'd5;
   localparam logic [DWELL_W-1:0] ELAPSED_MAX = 8'd255;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Digit positions
   localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd0;
   localparam logic [POS_W-1:0] POS_HUNDREDS  = 2'd1;
   localparam logic [POS_W-1:0] POS_TENS      = 2'd2;
   localparam logic [POS_W-1:0] POS_UNITS     = 2'd3;

   // Blanking thresholds
   localparam logic [VALUE_W-1:0] LIMIT_THOUSANDS = 14'd1000;
   localparam logic [VALUE_W-1:0] LIMIT_HUNDREDS  = 14'd100;
   localparam logic [VALUE_W-1:0] LIMIT_TENS      = 14'd10;

   // Reciprocals scaled by 2**RECIP_SHIFT, exact for every 14-bit value
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_1000 = 21'd16778;
   localparam logic [RECIP_W-1:0] RECIP_100  = 21'd167773;
   localparam logic [RECIP_W-1:0] RECIP_10   = 21'd1677722;

   // Divide-by-ten reciprocal for the modulo step, scaled by 2**TEN_SHIFT
   localparam int TEN_W     = 13;
   localparam int TEN_SHIFT = 16;
   localparam logic [TEN_W-1:0] RECIP_TEN = 13'd6554;

   // Code of the blank digit
   localparam logic [CODE_W-1:0] CODE_BLANK = 4'd10;

   // Last bit of a segment byte
   localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

   // One queue entry: segment byte and the digit position it belongs to
   typedef struct packed {
      logic [SEG_W-1:0] seg_byte;
      logic [POS_W-1:0] pos;
   } msd_entry_type;

   // Active-low segment byte for a digit code; blank for anything else
   function automatic logic [SEG_W-1:0] seg_lookup(input logic [CODE_W-1:0] code);
      logic [SEG_W-1:0] seg;
      unique case (code)
         4'd0:    seg = 8'd1;
         4'd1:    seg = 8'd79;
         4'd2:    seg = 8'd18;
         4'd3:    seg = 8'd6;
         4'd4:    seg = 8'd76;
         4'd5:    seg = 8'd36;
         4'd6:    seg = 8'd32;
         4'd7:    seg = 8'd15;
         4'd8:    seg = 8'd0;
         4'd9:    seg = 8'd4;
         default: seg = 8'd127;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/msd_stream_if.sv */
// Valid/ready channels of the seven-segment driver: refresh requests in,
// serial bit words out. Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface msd_req_if;
   logic                       valid;
   logic                       ready;
   logic [msd_pkg::VALUE_W-1:0] value_to_show;
   logic                       ms_tick;

   modport source (output valid, output value_to_show, output ms_tick, input ready);
   modport sink   (input valid, input value_to_show, input ms_tick, output ready);
endinterface

interface msd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [msd_pkg::DIGITS-1:0] digit_enable;
   logic                       serial_bit;
   logic [msd_pkg::BIT_W-1:0]  bit_position;
   logic                       latch_last;

   modport source (output valid, output digit_enable, output serial_bit,
                   output bit_position, output latch_last, input ready);
   modport sink   (input valid, input digit_enable, input serial_bit,
                   input bit_position, input latch_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/msd_front.sv */
// Front end: accepts refresh words, keeps the digit position and the
// millisecond counter, and works out the segment byte in three stages.
// Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msd_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [msd_pkg::DWELL_W-1:0]   csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [msd_pkg::VALUE_W-1:0]   req_value,
   input  wire logic                          req_tick,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output msd_pkg::msd_entry_type             push_entry
);
   import msd_pkg::*;

   logic [DWELL_W-1:0] dwell_ff, dwell_in;
   logic [DWELL_W-1:0] elapsed_ff, elapsed_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [VALUE_W-1:0] s1_value_ff;
   logic [POS_W-1:0]   s1_pos_ff;
   logic               s1_blank_ff;

   logic               s2_valid_ff, s2_valid_in;
   logic [QUOT_W-1:0]  s2_quot_ff, s2_quot_in;
   logic [POS_W-1:0]   s2_pos_ff;
   logic               s2_blank_ff;

   logic               s3_valid_ff, s3_valid_in;
   logic [QUOT_W-1:0]  s3_quot_ff;
   logic [QDIV_W-1:0]  s3_qdiv_ff, s3_qdiv_in;
   logic [POS_W-1:0]   s3_pos_ff;
   logic               s3_blank_ff;

   logic               accept;
   logic               take1, take2, take3;
   logic               blank_in;
   logic [DWELL_W-1:0] elapsed_inc;
   logic [RECIP_W-1:0] recip;
   logic [VALUE_W+RECIP_W-1:0] quot_prod;
   logic [QUOT_W+TEN_W-1:0]    qdiv_prod;
   logic [QUOT_W-1:0]  rem_full;
   logic [CODE_W-1:0]  code;

   // Stall chain: a stage takes a word when empty or when it passes its own on
   assign take3     = !s3_valid_ff || push_ready;
   assign take2     = !s2_valid_ff || take3;
   assign take1     = !s1_valid_ff || take2;
   assign req_ready = take1;
   assign accept    = req_valid && take1;

   // Dwell register
   always_comb begin
      dwell_in = csr_wr_en ? csr_wr_data : dwell_ff;
   end

   // Count milliseconds, saturate, advance the position once past the dwell
   always_comb begin
      elapsed_inc = elapsed_ff;
      if (req_tick && elapsed_ff != ELAPSED_MAX) begin
         elapsed_inc = elapsed_ff + 1'b1;
      end
      elapsed_in = elapsed_ff;
      pos_in     = pos_ff;
      if (accept) begin
         if (elapsed_inc > dwell_ff) begin
            elapsed_in = '0;
            pos_in     = pos_ff + 1'b1;
         end else begin
            elapsed_in = elapsed_inc;
         end
      end
   end

   // Blank leading zeros; a lone zero in the units still shows
   always_comb begin
      unique case (pos_ff)
         POS_THOUSANDS: blank_in = req_value < LIMIT_THOUSANDS;
         POS_HUNDREDS:  blank_in = req_value < LIMIT_HUNDREDS;
         POS_TENS:      blank_in = req_value < LIMIT_TENS;
         default:       blank_in = 1'b0;
      endcase
   end

   // Stage 2: quotient by the position's power of ten
   always_comb begin
      unique case (s1_pos_ff)
         POS_THOUSANDS: recip = RECIP_1000;
         POS_HUNDREDS:  recip = RECIP_100;
         default:       recip = RECIP_10;
      endcase
      quot_prod = (VALUE_W+RECIP_W)'(s1_value_ff) * (VALUE_W+RECIP_W)'(recip);
      if (s1_pos_ff == POS_UNITS) begin
         s2_quot_in = s1_value_ff;
      end else begin
         s2_quot_in = QUOT_W'(quot_prod >> RECIP_SHIFT);
      end
   end

   // Stage 3: quotient by ten for the modulo
   always_comb begin
      qdiv_prod  = (QUOT_W+TEN_W)'(s2_quot_ff) * (QUOT_W+TEN_W)'(RECIP_TEN);
      s3_qdiv_in = QDIV_W'(qdiv_prod >> TEN_SHIFT);
   end

   // Remainder, blanking and segment lookup on the way into the queue
   always_comb begin
      rem_full = s3_quot_ff - ((QUOT_W'(s3_qdiv_ff) << 3) + (QUOT_W'(s3_qdiv_ff) << 1));
      code     = s3_blank_ff ? CODE_BLANK : rem_full[CODE_W-1:0];
      push_entry.seg_byte = seg_lookup(code);
      push_entry.pos      = s3_pos_ff;
      push_valid          = s3_valid_ff;
   end

   // Stage valids
   always_comb begin
      s1_valid_in = take1 ? req_valid   : s1_valid_ff;
      s2_valid_in = take2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = take3 ? s2_valid_ff : s3_valid_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff    <= DWELL_RESET;
         elapsed_ff  <= '0;
         pos_ff      <= POS_THOUSANDS;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         dwell_ff    <= dwell_in;
         elapsed_ff  <= elapsed_in;
         pos_ff      <= pos_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload, moved when the stage takes a word
   always_ff @(posedge clock) begin
      if (take1) begin
         s1_value_ff <= req_value;
         s1_pos_ff   <= pos_ff;
         s1_blank_ff <= blank_in;
      end
      if (take2) begin
         s2_quot_ff  <= s2_quot_in;
         s2_pos_ff   <= s1_pos_ff;
         s2_blank_ff <= s1_blank_ff;
      end
      if (take3) begin
         s3_quot_ff  <= s2_quot_ff;
         s3_qdiv_ff  <= s3_qdiv_in;
         s3_pos_ff   <= s2_pos_ff;
         s3_blank_ff <= s2_blank_ff;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/msd_queue.sv */
// Short queue of segment entries between the front and back ends.
// Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msd_queue #(
   parameter int DEPTH = msd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push_valid,
   output logic                         push_ready,
   input  wire msd_pkg::msd_entry_type  push_entry,
   output logic                         pop_valid,
   input  wire logic                    pop_ready,
   output msd_pkg::msd_entry_type       pop_entry
);
   import msd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   msd_entry_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/msd_back.sv */
// Back end: shifts one segment byte out LSB first, one bit word per
// cycle while rsp is ready, with the digit select. Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   output logic                         pop_ready,
   input  wire msd_pkg::msd_entry_type  pop_entry,
   msd_rsp_if.source                    rsp
);
   import msd_pkg::*;

   logic             busy_ff, busy_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [SEG_W-1:0] byte_ff;
   logic [POS_W-1:0] pos_ff;
   logic             sent, last_sent;

   assign sent      = rsp.valid && rsp.ready;
   assign last_sent = sent && bit_ff == BIT_LAST;
   assign pop_ready = !busy_ff || last_sent;

   // Present the current bit word
   always_comb begin
      rsp.valid        = busy_ff;
      rsp.digit_enable = DIGITS'(1) << pos_ff;
      rsp.serial_bit   = byte_ff[bit_ff];
      rsp.bit_position = bit_ff;
      rsp.latch_last   = bit_ff == BIT_LAST;
   end

   // Step through the byte, load the next entry straight after the last bit
   always_comb begin
      busy_in = busy_ff;
      bit_in  = bit_ff;
      if (pop_ready) begin
         busy_in = pop_valid;
         bit_in  = '0;
      end else if (sent) begin
         bit_in = bit_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         bit_ff  <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         byte_ff <= pop_entry.seg_byte;
         pos_ff  <= pop_entry.pos;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/mux_seven_segment_driver_top.sv */
// Top level of the multiplexed four-digit seven-segment driver.
// Depends on msd_pkg, msd_stream_if, msd_front, msd_queue and msd_back.
//
// Each refresh word on req_stream carries the number to show and a
// millisecond flag; the block answers with eight bit words on rsp_stream,
// the active-low segment byte of the active digit LSB first, each with the
// one-hot digit select, the bit position and a flag on the eighth bit.
// Leading zeros are blanked. The position moves on once the millisecond
// count exceeds the dwell written through csr_wr_en/csr_wr_data (reset 5).
// The serial shifter sends one bit per cycle while rsp_stream is ready;
// up to the queue depth plus three words are taken ahead while earlier
// bytes are still shifting. An accepted word passes the front pipeline,
// the queue and the back end's byte register before its first bit word.
`timescale 1ns / 1ps
`default_nettype none

module mux_seven_segment_driver_top #(
   parameter int QUEUE_DEPTH = msd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [msd_pkg::DWELL_W-1:0] csr_wr_data,
   msd_req_if.sink                          req_stream,
   msd_rsp_if.source                        rsp_stream
);
   import msd_pkg::*;

   logic          push_valid, push_ready;
   msd_entry_type push_entry;
   logic          pop_valid, pop_ready;
   msd_entry_type pop_entry;

   // Accept and classify refresh words
   msd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_stream.valid),
      .req_ready   (req_stream.ready),
      .req_value   (req_stream.value_to_show),
      .req_tick    (req_stream.ms_tick),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_entry  (push_entry)
   );

   // Decouple front and back
   msd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Shift the segment bytes out
   msd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp       (rsp_stream)
   );

endmodule

`default_nettype wire
